// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros shared by checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// ===== rtl/core/rasr_pkg.sv =====
// ----------------------------------------------------------------------------
// rasr_pkg
// Shared types and constants of the region allocator.
// ----------------------------------------------------------------------------
package rasr_pkg;
   localparam int ENTRIES     = 256;
   localparam int IDX_BITS    = $clog2(ENTRIES);
   localparam int ADDR_BITS   = 48;
   localparam int ALIGN_BYTES = 8;
   localparam int ALIGN_BITS  = $clog2(ALIGN_BYTES);
   localparam int CNT_BITS    = IDX_BITS + 1;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [IDX_BITS-1:0]  idx_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_SPACE  = 3'd1,
      ST_UNKNOWN   = 3'd2,
      ST_TABLE_FULL = 3'd3,
      ST_DOUBLE_FREE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_WRITE, S_DONE
   } state_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Configuration register indexes.
   localparam logic REG_BASE = 1'b0;
   localparam logic REG_SIZE = 1'b1;

   // One table entry as stored in memory, flags included.
   typedef struct packed {
      addr_type    address;
      addr_type    size;
      logic [31:0] stamp;
      logic        valid;
      logic        in_use;
   } entry_type;

   // Memory write request from the sequencer.
   typedef struct packed {
      logic      we;
      idx_type   addr;
      entry_type data;
   } wr_type;
endpackage

// ===== rtl/core/rasr_table.sv =====
// ----------------------------------------------------------------------------
// rasr_table
// Entry table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rasr_table (
   input  logic                clock,
   input  rasr_pkg::wr_type    wr,
   input  rasr_pkg::idx_type   rd_addr,
   output rasr_pkg::entry_type rd_data
);
   rasr_pkg::entry_type mem [rasr_pkg::ENTRIES];
   rasr_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/region_allocator_size_reuse_top.sv =====
// ----------------------------------------------------------------------------
// region_allocator_size_reuse_top
// Bump allocator with exact-size reuse of freed table entries.
// ----------------------------------------------------------------------------
// channel | direction | contents
// req_    | in        | tdata: cmd, req_size, address
// rsp_    | out       | tdata: result_address, status, region_empty
// csr_    | in        | register write: 0 region_base, 1 region_size
//
// Every word takes a full scan of the entry table, one entry per cycle
// through the read port of the table memory. The scan covers all ENTRIES
// entries plus the read latency and a drain, then passes through a decide and
// a write state, after which the result is valid. The result is then handed
// over in the done state and the sequencer returns to idle. The scan takes no
// shortcut.
// Reset is synchronous and clears the counters and sequencer; a clearing pass
// over all ENTRIES entries then zeroes every table entry, valid and in-use
// flags included, while the request side stays not ready. A stalled result
// holds the sequencer in its done state; no new word is taken until it leaves.
module region_allocator_size_reuse_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [0] cmd, [48:1] req_size, [96:49] address, [103:97] zero
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [47:0] result_address, [50:48] status, [51] region_empty, [55:52] zero
   output logic [55:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [47:0]  csr_wdata
);
   localparam int AB = rasr_pkg::ADDR_BITS;

   rasr_pkg::state_type state_ff, state_in;
   rasr_pkg::addr_type  base_ff, size_ff, bump_ff, bump_in;
   logic [31:0]         seq_ff, seq_in;
   logic [rasr_pkg::CNT_BITS-1:0] live_ff, live_in;

   // Request registers.
   logic               cmd_ff;
   rasr_pkg::addr_type rsize_ff, raddr_ff;

   // Scan bookkeeping. The compare index is the read index of the cycle before.
   // The same counter walks the table during the clearing pass.
   logic [rasr_pkg::CNT_BITS-1:0] rd_cnt_ff, rd_cnt_in;
   rasr_pkg::idx_type  cmp_idx_ff;
   logic               cmp_vld_ff;
   logic               pick_ff, pick_in;
   rasr_pkg::idx_type  pick_idx_ff, pick_idx_in;
   logic [31:0]        pick_age_ff, pick_age_in;
   rasr_pkg::addr_type pick_addr_ff, pick_addr_in;
   logic               seen_ff, seen_in;
   logic               slot_ff, slot_in;
   rasr_pkg::idx_type  slot_idx_ff, slot_idx_in;

   // Fit check computed once per word in the decide state.
   rasr_pkg::addr_type aligned_ff, aligned_in;
   logic               fit_ff, fit_in;

   rasr_pkg::addr_type res_addr_ff, res_addr_in;
   rasr_pkg::status_type status_ff, status_in;

   rasr_pkg::wr_type    wr;
   rasr_pkg::entry_type rd_data;
   rasr_pkg::idx_type   rd_addr;

   assign rd_addr = rd_cnt_ff[rasr_pkg::IDX_BITS-1:0];

   rasr_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rasr_pkg::S_CLEAR:  if (rd_cnt_ff == rasr_pkg::CNT_BITS'(rasr_pkg::ENTRIES - 1))
                                state_in = rasr_pkg::S_IDLE;
         rasr_pkg::S_IDLE:   if (req_tvalid) state_in = rasr_pkg::S_SCAN;
         rasr_pkg::S_SCAN:   if (!cmp_vld_ff && rd_cnt_ff == rasr_pkg::CNT_BITS'(rasr_pkg::ENTRIES))
                                state_in = rasr_pkg::S_DECIDE;
         rasr_pkg::S_DECIDE: state_in = rasr_pkg::S_WRITE;
         rasr_pkg::S_WRITE:  state_in = rasr_pkg::S_DONE;
         rasr_pkg::S_DONE:   if (rsp_tready) state_in = rasr_pkg::S_IDLE;
         default:            state_in = rasr_pkg::S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      logic [AB:0]   lim_sum;
      logic [AB:0]   alg_sum;
      rasr_pkg::addr_type limit;
      logic [31:0]   age;
      logic          hit;
      rd_cnt_in    = rd_cnt_ff;
      pick_in      = pick_ff;
      pick_idx_in  = pick_idx_ff;
      pick_age_in  = pick_age_ff;
      pick_addr_in = pick_addr_ff;
      seen_in      = seen_ff;
      slot_in      = slot_ff;
      slot_idx_in  = slot_idx_ff;
      aligned_in   = aligned_ff;
      fit_in       = fit_ff;
      res_addr_in  = res_addr_ff;
      status_in    = status_ff;
      bump_in      = bump_ff;
      seq_in       = seq_ff;
      live_in      = live_ff;
      wr           = '0;
      age          = seq_ff - rd_data.stamp;
      hit          = 1'b0;
      lim_sum      = {1'b0, base_ff} + {1'b0, size_ff};
      limit        = lim_sum[AB] ? '1 : lim_sum[AB-1:0];
      alg_sum      = {1'b0, bump_ff} + (AB+1)'(rasr_pkg::ALIGN_BYTES - 1);
      req_tready   = (state_ff == rasr_pkg::S_IDLE);
      rsp_tvalid   = (state_ff == rasr_pkg::S_DONE);
      unique case (state_ff)
         rasr_pkg::S_CLEAR: begin
            // Zero one entry per cycle so that no entry reads as valid.
            rd_cnt_in = rd_cnt_ff + 1'b1;
            wr.we = 1'b1; wr.addr = rd_addr; wr.data = '0;
         end
         rasr_pkg::S_IDLE: begin
            rd_cnt_in = '0;
            pick_in = 1'b0; seen_in = 1'b0; slot_in = 1'b0;
            pick_age_in = '0;
         end
         rasr_pkg::S_SCAN: begin
            if (rd_cnt_ff != rasr_pkg::CNT_BITS'(rasr_pkg::ENTRIES)) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (cmp_vld_ff) begin
               if (!rd_data.valid) begin
                  if (!slot_ff) begin
                     slot_in = 1'b1; slot_idx_in = cmp_idx_ff;
                  end
               end else if (cmd_ff == rasr_pkg::CMD_ALLOC) begin
                  hit = !rd_data.in_use && rd_data.size == rsize_ff;
                  if (hit && (!pick_ff || age < pick_age_ff)) begin
                     pick_in = 1'b1; pick_idx_in = cmp_idx_ff;
                     pick_age_in = age; pick_addr_in = rd_data.address;
                  end
               end else if (rd_data.address == raddr_ff) begin
                  if (rd_data.in_use) begin
                     if (!pick_ff) begin
                        pick_in = 1'b1; pick_idx_in = cmp_idx_ff;
                     end
                  end else begin
                     seen_in = 1'b1;
                  end
               end
            end
         end
         rasr_pkg::S_DECIDE: begin
            aligned_in = {alg_sum[AB-1:rasr_pkg::ALIGN_BITS],
                          rasr_pkg::ALIGN_BITS'(0)};
            fit_in = !alg_sum[AB] && (aligned_in <= limit);
         end
         rasr_pkg::S_WRITE: begin
            res_addr_in = '0;
            status_in   = rasr_pkg::ST_OK;
            if (cmd_ff == rasr_pkg::CMD_FREE) begin
               if (raddr_ff == '0) begin
                  status_in = rasr_pkg::ST_OK;
               end else if (pick_ff) begin
                  wr.we = 1'b1; wr.addr = pick_idx_ff;
                  // Stamp rewrite needs the stored address and size; the read port holds
                  // nothing useful, so the size comes from the scan, the address from the request.
                  wr.data = '{address: raddr_ff, size: pick_addr_ff, stamp: seq_ff,
                              valid: 1'b1, in_use: 1'b0};
                  seq_in = seq_ff + 1'b1;
                  if (live_ff != '0) live_in = live_ff - 1'b1;
               end else begin
                  status_in = seen_ff ? rasr_pkg::ST_DOUBLE_FREE : rasr_pkg::ST_UNKNOWN;
               end
            end else if (pick_ff) begin
               // The stamp of an entry in use is never compared; it is
               // rewritten when the entry is freed again.
               wr.we = 1'b1; wr.addr = pick_idx_ff;
               wr.data = '{address: pick_addr_ff, size: rsize_ff, stamp: 32'd0,
                           valid: 1'b1, in_use: 1'b1};
               live_in = live_ff + 1'b1;
               res_addr_in = pick_addr_ff;
            end else if (!fit_ff || rsize_ff > limit - aligned_ff) begin
               status_in = rasr_pkg::ST_NO_SPACE;
            end else if (!slot_ff) begin
               status_in = rasr_pkg::ST_TABLE_FULL;
            end else begin
               wr.we = 1'b1; wr.addr = slot_idx_ff;
               wr.data = '{address: aligned_ff, size: rsize_ff, stamp: 32'd0,
                           valid: 1'b1, in_use: 1'b1};
               live_in = live_ff + 1'b1;
               bump_in = aligned_ff + rsize_ff;
               res_addr_in = aligned_ff;
            end
         end
         rasr_pkg::S_DONE: ;
         default: ;
      endcase
   end

   // For a free, the matched entry's size must survive the stamp rewrite:
   // capture it into pick_addr during the scan of free words.
   rasr_pkg::addr_type free_size_q;
   always_comb begin
      free_size_q = rd_data.size;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rasr_pkg::S_CLEAR;
         base_ff    <= '0;
         size_ff    <= rasr_pkg::addr_type'(262144);
         bump_ff    <= '0;
         seq_ff     <= '0;
         live_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         rd_cnt_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         seq_ff    <= seq_in;
         live_ff   <= live_in;
         rd_cnt_ff <= rd_cnt_in;
         // A base write restarts the bump pointer at the new base.
         if (csr_we && csr_index == rasr_pkg::REG_BASE) begin
            bump_ff <= csr_wdata;
         end else begin
            bump_ff <= bump_in;
         end
         cmp_vld_ff <= (state_ff == rasr_pkg::S_SCAN) &&
                       (rd_cnt_ff != rasr_pkg::CNT_BITS'(rasr_pkg::ENTRIES));
         if (csr_we) begin
            if (csr_index == rasr_pkg::REG_BASE) begin
               base_ff <= csr_wdata;
            end else begin
               size_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == rasr_pkg::S_IDLE && req_tvalid) begin
         cmd_ff   <= req_tdata[0];
         rsize_ff <= req_tdata[48:1];
         raddr_ff <= req_tdata[96:49];
      end
      cmp_idx_ff  <= rd_addr;
      pick_ff     <= pick_in;
      pick_idx_ff <= pick_idx_in;
      pick_age_ff <= pick_age_in;
      if (state_ff == rasr_pkg::S_SCAN && cmp_vld_ff && cmd_ff == rasr_pkg::CMD_FREE
          && pick_in && !pick_ff) begin
         pick_addr_ff <= free_size_q;
      end else begin
         pick_addr_ff <= pick_addr_in;
      end
      seen_ff     <= seen_in;
      slot_ff     <= slot_in;
      slot_idx_ff <= slot_idx_in;
      aligned_ff  <= aligned_in;
      fit_ff      <= fit_in;
      res_addr_ff <= res_addr_in;
      status_ff   <= status_in;
   end

   assign rsp_tdata = {4'b0, (live_ff == '0), status_ff, res_addr_ff};
endmodule

// ===== rtl/core/rasr_checker.sv =====
// ----------------------------------------------------------------------------
// rasr_checker
// Port-level checks of the region allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rasr_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [55:0]  rsp_tdata
);
   `CHK_IMPLY(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `CHK_IMPLY(a_status_range, clock, reset, rsp_tvalid, rsp_tdata[50:48] <= rasr_pkg::ST_DOUBLE_FREE)
   `CHK_IMPLY(a_fail_zero, clock, reset, rsp_tvalid && rsp_tdata[50:48] != rasr_pkg::ST_OK,
              rsp_tdata[47:0] == 48'd0)
   `CHK_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)
endmodule

bind region_allocator_size_reuse_top rasr_checker u_rasr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the region allocator. Allocate and free words are
// driven over the request stream. A scoreboard class predicts each result
// word from its own copy of the table, bump pointer and region registers,
// and checks the result stream in order.
// ----------------------------------------------------------------------------

// Scoreboard: holds the predicted allocator state and the expected results.
class alloc_scoreboard;
   localparam bit [63:0] AMASK = 64'hFFFF_FFFF_FFFF;

   typedef struct {
      rasr_pkg::addr_type   address;
      rasr_pkg::status_type status;
      bit                   empty;
   } outcome_type;

   bit [63:0]   base_reg;
   bit [63:0]   size_reg;
   bit [63:0]   bump;
   bit [47:0]   ent_addr [rasr_pkg::ENTRIES];
   bit [47:0]   ent_size [rasr_pkg::ENTRIES];
   bit [31:0]   ent_stamp [rasr_pkg::ENTRIES];
   bit          ent_valid [rasr_pkg::ENTRIES];
   bit          ent_busy [rasr_pkg::ENTRIES];
   bit [31:0]   free_seq;
   int unsigned live;
   outcome_type pending_q[$];
   int unsigned errors;

   function new();
      base_reg = 0;
      size_reg = 64'd262144;
      bump     = 0;
      free_seq = 0;
      live     = 0;
      errors   = 0;
      foreach (ent_valid[i]) begin
         ent_valid[i] = 0;
         ent_busy[i]  = 0;
      end
   endfunction

   task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   function void write_reg(logic idx, bit [47:0] value);
      if (idx == rasr_pkg::REG_BASE) begin
         base_reg = {16'd0, value};
         bump     = {16'd0, value};
      end else begin
         size_reg = {16'd0, value};
      end
   endfunction

   function int unsigned pending();
      return pending_q.size();
   endfunction

   function bit table_full();
      foreach (ent_valid[i])
         if (!ent_valid[i]) return 0;
      return 1;
   endfunction

   // Address of a random table entry, or a random address if the table is empty.
   function bit [47:0] any_address();
      int idx[$];
      foreach (ent_valid[i])
         if (ent_valid[i]) idx = {idx, i};
      if (idx.size() == 0) return 48'({$urandom, $urandom});
      return ent_addr[idx[$urandom_range(0, idx.size() - 1)]];
   endfunction

   function rasr_pkg::status_type allocate(bit [47:0] sz, output bit [47:0] addr);
      int        pick, slot;
      bit [31:0] age, best;
      bit [63:0] lim, aligned;
      pick = -1;
      slot = -1;
      best = 0;
      addr = 0;
      // Exact-size reuse picks the most recently freed entry.
      for (int i = 0; i < rasr_pkg::ENTRIES; i++) begin
         if (ent_valid[i] && !ent_busy[i] && ent_size[i] == sz) begin
            age = free_seq - ent_stamp[i];
            if (pick < 0 || age < best) begin
               pick = i;
               best = age;
            end
         end
      end
      if (pick >= 0) begin
         ent_busy[pick] = 1;
         live++;
         addr = ent_addr[pick];
         return rasr_pkg::ST_OK;
      end
      // The region end saturates at the top of the address space.
      if (size_reg > AMASK - base_reg) lim = AMASK;
      else lim = base_reg + size_reg;
      if (bump > AMASK - 64'd7) return rasr_pkg::ST_NO_SPACE;
      aligned = (bump + 64'd7) & ~64'd7;
      if (aligned > lim || {16'd0, sz} > lim - aligned) return rasr_pkg::ST_NO_SPACE;
      for (int i = 0; i < rasr_pkg::ENTRIES; i++) begin
         if (!ent_valid[i]) begin
            slot = i;
            break;
         end
      end
      if (slot < 0) return rasr_pkg::ST_TABLE_FULL;
      ent_valid[slot] = 1;
      ent_busy[slot]  = 1;
      ent_addr[slot]  = aligned[47:0];
      ent_size[slot]  = sz;
      live++;
      bump = aligned + {16'd0, sz};
      addr = aligned[47:0];
      return rasr_pkg::ST_OK;
   endfunction

   function rasr_pkg::status_type release_addr(bit [47:0] a);
      bit seen;
      seen = 0;
      if (a == 0) return rasr_pkg::ST_OK;
      for (int i = 0; i < rasr_pkg::ENTRIES; i++) begin
         if (ent_valid[i] && ent_addr[i] == a) begin
            if (ent_busy[i]) begin
               ent_busy[i]  = 0;
               ent_stamp[i] = free_seq;
               free_seq++;
               if (live > 0) live--;
               return rasr_pkg::ST_OK;
            end
            seen = 1;
         end
      end
      return seen ? rasr_pkg::ST_DOUBLE_FREE : rasr_pkg::ST_UNKNOWN;
   endfunction

   // Called for every accepted request word.
   function void note_request(logic cmd, bit [47:0] sz, bit [47:0] a);
      outcome_type o;
      o.address = 0;
      if (cmd == rasr_pkg::CMD_FREE) o.status = release_addr(a);
      else o.status = allocate(sz, o.address);
      o.empty = (live == 0);
      pending_q = {pending_q, o};
   endfunction

   // Called for every accepted result word.
   task check_result(logic [55:0] d);
      outcome_type o;
      if (pending_q.size() == 0) begin
         report($sformatf("result word with nothing expected: %h", d));
         return;
      end
      o = pending_q.pop_front();
      if (d[47:0] !== o.address)
         report($sformatf("address got %h want %h", d[47:0], o.address));
      if (d[50:48] !== o.status)
         report($sformatf("status got %0d want %0d", d[50:48], o.status));
      if (d[51] !== o.empty)
         report($sformatf("region_empty got %b want %b", d[51], o.empty));
   endtask
endclass

module testbench;
   localparam int unsigned LONG_HOLD = 1500;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [55:0]  rsp_tdata;
   logic         csr_we;
   logic         csr_index;
   logic [47:0]  csr_wdata;

   alloc_scoreboard sb = new();

   // When set, neither side inserts idle cycles.
   bit          no_idle = 0;
   // Each increment asks the receiver for one long hold-off.
   int unsigned hold_requests = 0;

   // Sizes drawn most of the time, so that freed entries get reused.
   bit [47:0] size_pool [8] = '{48'd0, 48'd1, 48'd7, 48'd8, 48'd16, 48'd24, 48'd40, 48'd100};

   region_allocator_size_reuse_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Drive one request word. A zero gap keeps tvalid high from the previous
   // word, so tvalid sees only one assignment per edge.
   task send_word(logic cmd, bit [47:0] sz, bit [47:0] a);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, a, sz, cmd};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, sz, a);
   endtask

   task alloc_word(bit [47:0] sz);
      send_word(rasr_pkg::CMD_ALLOC, sz, 48'({$urandom, $urandom}));
   endtask

   task free_word(bit [47:0] a);
      send_word(rasr_pkg::CMD_FREE, 48'({$urandom, $urandom}), a);
   endtask

   // Wait until every expected result has come back; the block produces one
   // result per word, so a short margin is enough before touching registers.
   task drain();
      @(posedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task write_reg(logic idx, bit [47:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   // One random word: mostly pool-size allocations and frees of live entries,
   // with some odd sizes, random addresses and no-op frees mixed in.
   task random_word(int unsigned span);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 42) alloc_word(size_pool[$urandom_range(0, 7)]);
      else if (r < 54) alloc_word(48'($urandom_range(1, span)));
      else if (r < 58) alloc_word(48'({$urandom, $urandom}));
      else if (r < 86) free_word(sb.any_address());
      else if (r < 94) free_word(48'({$urandom, $urandom}));
      else free_word(48'd0);
   endtask

   // Receiver: random stalls, an optional long hold-off, then take one word.
   initial begin
      int unsigned gap;
      int unsigned holds_done;
      rsp_tready = 1'b0;
      holds_done = 0;
      @(negedge reset);
      forever begin
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         gap = no_idle ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Hard limit on the run, several times the slowest legal run.
   initial begin
      #8000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = 1'b0;
      csr_wdata  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the reset configuration: base 0, size 256 KiB.
      free_word(48'd0);                  // no-op free on an empty table
      free_word(48'h1234);               // unknown address
      alloc_word(48'd0);                 // zero size at address zero
      alloc_word(48'd0);                 // second zero-size entry shares it
      alloc_word(48'd5);                 // still at zero, bump moves to 5
      alloc_word(48'd3);                 // aligned up to 8
      free_word(48'd8);
      free_word(48'd8);                  // double free
      alloc_word(48'd3);                 // exact-size reuse of 8
      alloc_word(48'd16);
      alloc_word(48'd16);
      free_word(48'd16);
      free_word(48'd32);
      alloc_word(48'd16);                // most recently freed entry wins
      alloc_word(48'hFFFF_FFFF_FFFF);    // no space
      alloc_word(48'd262144);            // no space once the bump pointer moved up
      free_word(48'd0);                  // address zero stays a no-op
      free_word(48'hFFFF_FFFF_FFFF);
      drain();

      // Region at the very top of the address space, end saturated.
      write_reg(rasr_pkg::REG_BASE, 48'hFFFF_FFFF_FF00);
      write_reg(rasr_pkg::REG_SIZE, 48'hFFFF_FFFF_FFFF);
      alloc_word(48'hF8);
      alloc_word(48'd7);                 // ends exactly at the top
      alloc_word(48'd1);                 // rounding would wrap: no space
      drain();

      // Unaligned base and an empty region.
      write_reg(rasr_pkg::REG_BASE, 48'h13);
      write_reg(rasr_pkg::REG_SIZE, 48'h100);
      alloc_word(48'd1);
      drain();
      write_reg(rasr_pkg::REG_BASE, 48'h1000);
      write_reg(rasr_pkg::REG_SIZE, 48'd0);
      alloc_word(48'd0);
      alloc_word(48'd1);
      drain();

      // Random phase in a roomy region, with a long receiver hold-off midway
      // so the block backs up and stalls its request side.
      write_reg(rasr_pkg::REG_BASE, 48'h10000);
      write_reg(rasr_pkg::REG_SIZE, 48'h40000);
      for (int i = 0; i < 100; i++) begin
         if (i == 50) hold_requests++;
         random_word(256);
      end
      drain();

      // Tight region: frequent no-space outcomes; reuse still works.
      write_reg(rasr_pkg::REG_BASE, 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFF8);
      write_reg(rasr_pkg::REG_SIZE, 48'h400);
      for (int i = 0; i < 80; i++) random_word(64);
      drain();

      // Whole address space, both sides without idle cycles.
      no_idle = 1;
      write_reg(rasr_pkg::REG_BASE, 48'd0);
      write_reg(rasr_pkg::REG_SIZE, 48'hFFFF_FFFF_FFFF);
      for (int i = 0; i < 60; i++) random_word(4096);
      drain();
      no_idle = 0;

      // Fill the table with fresh sizes, then exercise the full table.
      write_reg(rasr_pkg::REG_BASE, 48'h10_0000);
      write_reg(rasr_pkg::REG_SIZE, 48'h100_0000);
      while (!sb.table_full()) alloc_word(48'($urandom_range(200, 4096)));
      for (int i = 0; i < 40; i++) begin
         if ($urandom_range(0, 3) == 0) alloc_word(48'($urandom_range(5000, 9000)));
         else random_word(4096);
      end

      drain();
      repeat (300) @(posedge clock);
      if (sb.pending() != 0) sb.report($sformatf("%0d results never came", sb.pending()));
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
